// ===== src/interval_sort_merge_macros.svh =====
// ---------------------------------------------------------------------------
// interval_sort_merge_macros
// assertion macros shared by the interval sort and merge block
// ---------------------------------------------------------------------------
`ifndef INTERVAL_SORT_MERGE_MACROS_SVH
`define INTERVAL_SORT_MERGE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ISM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval_sort_merge: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ISM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval_sort_merge: next-cycle check failed");

`endif

// ===== src/ism_pkg.sv =====
// ---------------------------------------------------------------------------
// ism_pkg
// types and constants of the interval sort and merge block
// ---------------------------------------------------------------------------
package ism_pkg;

   localparam int POS_W = 31;

   // one stored interval
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] stop;
      logic             open;
   } entry_type;

   // per-cycle command to the cell row
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

   // block state, one-hot
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, start: '0, stop: '0, open: 1'b0};

endpackage

// ===== src/ism_cell.sv =====
// ---------------------------------------------------------------------------
// ism_cell
// one slot of the sorting row: holds an interval, takes the new one or its
// left neighbor on insert, takes its right neighbor on pop
// ---------------------------------------------------------------------------
module ism_cell
   import ism_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     prev_entry,
   input  logic          prev_gt,
   input  entry_type     next_entry,
   output entry_type     entry,
   output logic          gt
);

   entry_type entry_ff;
   entry_type entry_in;

   // empty slots count as greater so the row fills from the left
   assign gt    = !entry_ff.valid || (entry_ff.start > new_entry.start);
   assign entry = entry_ff;

   // next slot content
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && gt) begin
         entry_in = prev_gt ? prev_entry : new_entry;
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   // slot register, only the valid flag is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.start <= entry_in.start;
      entry_ff.stop  <= entry_in.stop;
      entry_ff.open  <= entry_in.open;
   end

endmodule

// ===== src/ism_merge.sv =====
// ---------------------------------------------------------------------------
// ism_merge
// merges the sorted intervals popped from the head of the row and holds
// each finished interval in the output register
// ---------------------------------------------------------------------------
module ism_merge
   import ism_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             drain,
   input  entry_type        head,
   input  logic             reject,
   output logic             pop,
   output logic             finish,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // rsp_tdata: merged_start[30:0], merged_end[61:31], merged_open[62], zero[63]
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tlast,
   // rsp_tuser: rejected_any
   output logic             rsp_tuser
);

   entry_type        acc_ff, acc_in;
   logic             acc_valid_ff, acc_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic [POS_W-1:0] out_start_ff, out_start_in;
   logic [POS_W-1:0] out_stop_ff, out_stop_in;
   logic             out_open_ff, out_open_in;
   logic             out_last_ff, out_last_in;
   logic             out_rej_ff, out_rej_in;
   logic             slot_free;
   logic             joins;
   logic             emit;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign joins     = acc_ff.open || (head.start <= acc_ff.stop);

   // merge step
   always_comb begin
      acc_in       = acc_ff;
      acc_valid_in = acc_valid_ff;
      pop          = 1'b0;
      finish       = 1'b0;
      emit         = 1'b0;
      out_last_in  = 1'b0;
      if (drain) begin
         if (head.valid) begin
            if (acc_valid_ff && joins) begin
               pop = 1'b1;
               if (!acc_ff.open) begin
                  if (head.open) begin
                     acc_in.open = 1'b1;
                  end else if (head.stop > acc_ff.stop) begin
                     acc_in.stop = head.stop;
                  end
               end
            end else if (acc_valid_ff) begin
               if (slot_free) begin
                  emit   = 1'b1;
                  pop    = 1'b1;
                  acc_in = head;
               end
            end else begin
               pop          = 1'b1;
               acc_in       = head;
               acc_valid_in = 1'b1;
            end
         end else if (slot_free) begin
            emit         = 1'b1;
            out_last_in  = 1'b1;
            finish       = 1'b1;
            acc_valid_in = 1'b0;
         end
      end
   end

   // output register next values; empty set gives an all-zero interval
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_start_in = out_start_ff;
      out_stop_in  = out_stop_ff;
      out_open_in  = out_open_ff;
      out_rej_in   = out_rej_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_start_in = acc_valid_ff ? acc_ff.start : '0;
         out_stop_in  = (acc_valid_ff && !acc_ff.open) ? acc_ff.stop : '0;
         out_open_in  = acc_valid_ff && acc_ff.open;
         out_rej_in   = reject;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      out_start_ff <= out_start_in;
      out_stop_ff  <= out_stop_in;
      out_open_ff  <= out_open_in;
      if (emit) begin
         out_last_ff <= out_last_in;
      end
      out_rej_ff   <= out_rej_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_open_ff, out_stop_ff, out_start_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_rej_ff;

endmodule

// ===== src/interval_sort_merge.sv =====
// ---------------------------------------------------------------------------
// interval_sort_merge
// collects inclusive 1-based intervals, keeps them sorted by start in a row
// of cells, and on the last request streams out the merged intervals
// ---------------------------------------------------------------------------
// While a set is loading, one request is taken every cycle: each interval is
// compared against all cells in parallel and registered into place directly,
// equal starts kept in arrival order. A request with tlast starts the
// drain: the row shifts toward cell 0 one interval per cycle into the merge
// unit, unless a finished interval waits on a full, stalled output register, and
// no request is taken until the final merged interval (tlast) has been loaded
// into the output register. Intervals with a zero position, with start greater
// than end, or arriving with MAX_INTERVALS stored are dropped and reported on
// tuser of every result of the set. An empty set gives one all-zero result.
module interval_sort_merge
   import ism_pkg::*;
#(
   parameter int MAX_INTERVALS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata: start_line[30:0], end_line[61:31], end_open[62], zero[63]
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: merged_start[30:0], merged_end[61:31], merged_open[62], zero[63]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: rejected_any
   output logic        rsp_tuser
);

   `include "interval_sort_merge_macros.svh"

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             reject_ff, reject_in;
   logic             accept;
   logic             bad;
   logic             full;
   logic             pop;
   logic             finish;
   cell_ctrl_type    ctrl;
   entry_type        new_entry;
   logic [POS_W-1:0] in_start, in_stop;
   logic             in_open;

   entry_type        cells [MAX_INTERVALS];
   logic             gts   [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] valid_vec;

   assign in_start = req_tdata[POS_W-1:0];
   assign in_stop  = req_tdata[2*POS_W-1:POS_W];
   assign in_open  = req_tdata[2*POS_W];

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;

   // request checks
   assign bad  = (in_start == '0) || (!in_open && ((in_stop == '0) || (in_start > in_stop)));
   assign full = (count_ff == CNT_W'(MAX_INTERVALS));

   assign new_entry = '{valid: 1'b1, start: in_start,
                        stop: in_open ? '0 : in_stop, open: in_open};

   assign ctrl.insert = accept && !bad && !full;
   assign ctrl.pop    = pop;

   // row of sorting cells
   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_g;
      if (i == 0) begin : g_first
         assign prev_e = EMPTY_ENTRY;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_e = cells[i-1];
         assign prev_g = gts[i-1];
      end
      if (i == MAX_INTERVALS - 1) begin : g_last
         assign next_e = EMPTY_ENTRY;
      end else begin : g_inner
         assign next_e = cells[i+1];
      end
      ism_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .prev_gt    (prev_g),
         .next_entry (next_e),
         .entry      (cells[i]),
         .gt         (gts[i])
      );
      assign valid_vec[i] = cells[i].valid;
   end

   // merge unit and output register
   ism_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .drain      (state_ff == ST_DRAIN),
      .head       (cells[0]),
      .reject     (reject_ff),
      .pop        (pop),
      .finish     (finish),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // control next state
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      reject_in = reject_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (ctrl.insert) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  reject_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in  = ST_LOAD;
               count_in  = '0;
               reject_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         reject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         reject_ff <= reject_in;
      end
   end

   // row invariants for checking
   logic order_ok;
   logic packed_ok;
   always_comb begin
      order_ok  = 1'b1;
      packed_ok = 1'b1;
      for (int k = 1; k < MAX_INTERVALS; k++) begin
         if (cells[k].valid && (cells[k-1].start > cells[k].start)) begin
            order_ok = 1'b0;
         end
         if (cells[k].valid && !cells[k-1].valid) begin
            packed_ok = 1'b0;
         end
      end
   end

   `ISM_ASSERT_IMP(a_row_sorted, clock, reset, 1'b1, order_ok)
   `ISM_ASSERT_IMP(a_row_packed, clock, reset, 1'b1, packed_ok)
   `ISM_ASSERT_IMP(a_count_match, clock, reset, state_ff == ST_LOAD,
                   $countones(valid_vec) == int'(count_ff))
   `ISM_ASSERT_NXT(a_finish_clears, clock, reset, finish,
                   !reject_ff && (count_ff == '0) && !cells[0].valid)

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// testbench of the interval sort and merge block
// ---------------------------------------------------------------------------
// Interval sets go into the block on the request stream, each set closed by
// tlast. A small scoreboard keeps its own sorted copy of every set and merges
// it when the closing request is taken. Every merged interval that comes back
// is compared field by field with the oldest prediction. A directed part
// covers the corner cases. A random part follows, mostly well-formed sets with
// some dropped intervals and two sets at full capacity. Both sides stall at
// random, with one long hold on the response side.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CAPACITY       = 64;
   localparam int          RANDOM_ITEMS   = 300;
   localparam longint      TIMEOUT_CYCLES = 1_000_000;
   localparam bit [30:0]   POS_MAX        = 31'h7FFF_FFFF;

   // one merged interval as it should leave the block
   typedef struct {
      bit [30:0] first_pos;
      bit [30:0] last_pos;
      bit        open;
      bit        fin;
      bit        dropped;
   } merged_t;

   // one interval held for the current set
   typedef struct {
      bit [30:0] first_pos;
      bit [30:0] last_pos;
      bit        open;
   } span_t;

   // keeps the current set sorted and the merged intervals still owed
   class interval_merge_board;
      span_t   held[$];
      merged_t awaited[$];
      bit      dropped_any;
      int      capacity;
      int      errors;

      function new(int cap);
         capacity    = cap;
         dropped_any = 1'b0;
         errors      = 0;
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void owe(bit [30:0] s, bit [30:0] e, bit op, bit fin);
         merged_t m;
         m.first_pos = s;
         m.last_pos  = op ? 31'd0 : e;
         m.open      = op;
         m.fin       = fin;
         m.dropped   = dropped_any;
         awaited.push_back(m);
      endfunction

      // store one accepted request; merge the set on the closing one
      function void note_request(bit [30:0] s, bit [30:0] e, bit op, bit last);
         bit        bad;
         int        k;
         span_t     item;
         bit [30:0] cur_s;
         bit [30:0] cur_e;
         bit        cur_o;
         if (op) e = '0;
         bad = (s == 0) || (!op && (e == 0 || s > e));
         if (bad || held.size() >= capacity) begin
            dropped_any = 1'b1;
         end else begin
            // stable: goes after every held start not above its own
            k = held.size();
            while (k > 0 && held[k-1].first_pos > s) k--;
            item.first_pos = s;
            item.last_pos  = e;
            item.open      = op;
            held.insert(k, item);
         end
         if (!last) return;
         if (held.size() == 0) begin
            owe('0, '0, 1'b0, 1'b1);
         end else begin
            cur_s = held[0].first_pos;
            cur_e = held[0].last_pos;
            cur_o = held[0].open;
            for (int i = 1; i < held.size(); i++) begin
               if (cur_o || held[i].first_pos <= cur_e) begin
                  // overlap: extend the current run
                  if (!cur_o) begin
                     if (held[i].open) cur_o = 1'b1;
                     else if (held[i].last_pos > cur_e) cur_e = held[i].last_pos;
                  end
               end else begin
                  owe(cur_s, cur_e, cur_o, 1'b0);
                  cur_s = held[i].first_pos;
                  cur_e = held[i].last_pos;
                  cur_o = held[i].open;
               end
            end
            owe(cur_s, cur_e, cur_o, 1'b1);
         end
         held.delete();
         dropped_any = 1'b0;
      endfunction

      task check_response(logic [63:0] data, logic fin, logic dropped);
         merged_t want;
         if (awaited.size() == 0) begin
            report($sformatf("response with nothing owed, start %0d", data[30:0]));
            return;
         end
         want = awaited.pop_front();
         if (data[30:0] !== want.first_pos)
            report($sformatf("merged start %0d, want %0d", data[30:0], want.first_pos));
         if (data[61:31] !== want.last_pos)
            report($sformatf("merged end %0d, want %0d", data[61:31], want.last_pos));
         if (data[62] !== want.open)
            report($sformatf("merged open %b, want %b", data[62], want.open));
         if (fin !== want.fin)
            report($sformatf("tlast %b, want %b", fin, want.fin));
         if (dropped !== want.dropped)
            report($sformatf("dropped flag %b, want %b", dropped, want.dropped));
      endtask

      task finish_check();
         if (awaited.size() != 0)
            report($sformatf("%0d merged intervals never came", awaited.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   interval_merge_board board;
   bit                  sender_calm = 1'b0;

   interval_sort_merge #(.MAX_INTERVALS(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // free-running clock
   initial begin
      forever #10 clock = ~clock;
   end

   // offer one interval until the block takes it
   task send_interval(bit [30:0] s, bit [30:0] e, bit op, bit last);
      if (!sender_calm && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, op, e, s};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(s, e, op, last);
   endtask

   task wait_drained();
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   // positions: mostly small so sets overlap, some wide, a few zero
   function automatic bit [30:0] pick_pos();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 31'($urandom_range(1, 40));
      if (roll < 85) return 31'($urandom);
      if (roll < 90) return '0;
      return POS_MAX - 31'($urandom_range(0, 20));
   endfunction

   function automatic bit [30:0] pick_end(bit [30:0] s);
      bit [31:0] sum;
      if ($urandom_range(0, 9) == 0) return pick_pos();
      sum = {1'b0, s} + 32'($urandom_range(0, 12));
      return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[30:0];
   endfunction

   // response side: random stalls, one long hold, one calm stretch
   initial begin : response_side
      int taken;
      int hold_left;
      taken     = 0;
      hold_left = 0;
      @(negedge reset);
      forever begin
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (taken >= 100 && taken < 160) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 10);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata, rsp_tlast, rsp_tuser);
            taken++;
            if (taken == 30) hold_left = 300;
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("Verification failed");
      $finish;
   end

   // request side: directed sets, then random sets
   initial begin : request_side
      int        sent;
      int        set_idx;
      int        set_len;
      bit [30:0] s;
      board = new(CAPACITY);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // dropped closing request on an empty set
      send_interval(31'd0, 31'd5, 1'b0, 1'b1);
      // touching intervals stay apart
      send_interval(31'd3, 31'd4, 1'b0, 1'b0);
      send_interval(31'd1, 31'd2, 1'b0, 1'b1);
      // overlap at equal position, zero end, start above end, open end absorbs
      send_interval(31'd5, 31'd10, 1'b0, 1'b0);
      send_interval(31'd1, 31'd5, 1'b0, 1'b0);
      send_interval(31'd7, 31'd9, 1'b0, 1'b0);
      send_interval(31'd12, 31'd0, 1'b0, 1'b0);
      send_interval(31'd20, 31'd15, 1'b0, 1'b0);
      send_interval(31'd5, 31'd8, 1'b0, 1'b0);
      send_interval(31'd40, 31'd3, 1'b1, 1'b0);
      send_interval(31'd45, 31'd50, 1'b0, 1'b0);
      send_interval(31'd30, 31'd41, 1'b0, 1'b1);
      // extreme positions, closing request dropped but merge still runs
      send_interval(POS_MAX, POS_MAX, 1'b0, 1'b0);
      send_interval(31'd1, POS_MAX - 31'd1, 1'b0, 1'b0);
      send_interval(31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 1'b0);
      send_interval(31'd100, 31'd99, 1'b0, 1'b1);
      // single open interval with zero end, single point
      send_interval(31'h5555_5555, 31'd0, 1'b1, 1'b1);
      send_interval(31'd6, 31'd6, 1'b0, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // random sets, two of them at and past capacity
      sent    = 0;
      set_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         sender_calm = (set_idx >= 25 && set_idx < 35);
         if (set_idx == 5) set_len = CAPACITY + 2;
         else if (set_idx == 12) set_len = CAPACITY;
         else set_len = $urandom_range(1, 8);
         for (int i = 0; i < set_len; i++) begin
            s = pick_pos();
            send_interval(s, pick_end(s), $urandom_range(0, 9) == 0, i == set_len - 1);
            sent++;
         end
         // once, let every merged interval come back before going on
         if (set_idx == 20) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         set_idx++;
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      board.finish_check();
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
